### sv/assert_macros.svh
// Assertion macros used by the top level of the reply field extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define DRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### sv/dre_pkg.sv
// Types and constants shared by the reply field extractor modules.
package dre_pkg;

	// Header layout and protocol constants.
	localparam int unsigned MinLen    = 245;
	localparam int unsigned OptBase   = 240;
	localparam int unsigned XidFirst  = 4;
	localparam int unsigned XidLast   = 7;
	localparam int unsigned YiFirst   = 16;
	localparam int unsigned YiLast    = 19;
	localparam int unsigned MacFirst  = 28;
	localparam int unsigned MacLast   = 33;
	localparam int unsigned CookFirst = 236;
	localparam int unsigned CookLast  = 239;
	localparam logic [7:0]  ReplyOp   = 8'd2;
	localparam logic [31:0] DefaultLease = 32'd60;
	localparam logic [7:0]  OptPad    = 8'd0;
	localparam logic [7:0]  OptEnd    = 8'd255;

	// Depth of the queue between front and back.
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);

	// Wanted options, in the order of their captured slots.
	localparam int unsigned NumWanted = 6;
	localparam int unsigned SlotMsg   = 0;
	localparam int unsigned SlotSrv   = 1;
	localparam int unsigned SlotLease = 2;
	localparam int unsigned SlotMask  = 3;
	localparam int unsigned SlotGw    = 4;
	localparam int unsigned SlotDns   = 5;

	typedef logic [7:0] byte_t;

	localparam byte_t WantCode [NumWanted] = '{8'd53, 8'd54, 8'd51, 8'd1, 8'd3, 8'd6};
	localparam byte_t WantLen  [NumWanted] = '{8'd1, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4};

	// Magic cookie bytes in wire order.
	localparam byte_t Cookie [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

	// Configuration register indexes.
	localparam logic CfgOwnMac = 1'b0;
	localparam logic CfgXid    = 1'b1;

	typedef enum logic [2:0] {
		VERD_OK         = 3'd0,
		VERD_SHORT      = 3'd1,
		VERD_NOT_REPLY  = 3'd2,
		VERD_BAD_COOKIE = 3'd3,
		VERD_OTHER_MAC  = 3'd4,
		VERD_XID        = 3'd5
	} verdict_t;

	// One classified byte, as the front hands it to the back.
	typedef struct packed {
		byte_t data;
		logic  last;
		logic  short_pkt;
		logic  op_bad;
		logic  cookie_bad;
		logic  mac_bad;
		logic  is_xid;
		logic  is_yi;
		logic  is_opt;
	} item_t;

	// Queue fill status.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One packet summary.
	typedef struct packed {
		verdict_t    verdict;
		byte_t       message_kind;
		logic [31:0] offered_ip;
		logic        server_id_ok;
		logic [31:0] server_addr;
		logic        lease_present;
		logic [31:0] lease_secs;
		logic [31:0] netmask;
		logic [31:0] gateway_ip;
		logic [31:0] name_server_ip;
	} summary_t;

endpackage

### sv/dre_byte_if.sv
// Channel that carries packet bytes with a last-byte flag.
interface dre_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### sv/dre_sum_if.sv
// Channel that carries one packet summary per transfer.
interface dre_sum_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [7:0]  message_kind;
	logic [31:0] offered_ip;
	logic        server_id_ok;
	logic [31:0] server_addr;
	logic        lease_present;
	logic [31:0] lease_secs;
	logic [31:0] netmask;
	logic [31:0] gateway_ip;
	logic [31:0] name_server_ip;

	modport source (output valid, output verdict, output message_kind, output offered_ip,
		output server_id_ok, output server_addr, output lease_present, output lease_secs,
		output netmask, output gateway_ip, output name_server_ip, input ready);
	modport sink (input valid, input verdict, input message_kind, input offered_ip,
		input server_id_ok, input server_addr, input lease_present, input lease_secs,
		input netmask, input gateway_ip, input name_server_ip, output ready);
endinterface

### sv/dre_front.sv
// Front end: accepts packet bytes, counts offsets and classifies each byte.
module dre_front import dre_pkg::*; #(
	parameter int unsigned MAX_BYTES = 1500
) (
	input  logic          clk,
	input  logic          arst_n,
	dre_byte_if.sink      pkt_in,
	input  logic [47:0]   own_mac,
	input  q_stat_t       q_stat,
	output logic          push,
	output item_t         push_item
);

	localparam int unsigned CntW = $clog2(MAX_BYTES + 1);

	logic [CntW-1:0] offset_q;
	logic [CntW-1:0] mac_rel;
	logic [CntW-1:0] count_next;
	logic            take;
	byte_t           mac_byte;
	byte_t           b;

	assign pkt_in.ready = !q_stat.full;
	assign push         = pkt_in.valid && pkt_in.ready;
	assign b            = pkt_in.data_byte;

	// Bytes past the size limit are counted no further and stay unclassified.
	assign take       = offset_q < CntW'(MAX_BYTES);
	assign count_next = take ? offset_q + CntW'(1) : offset_q;
	assign mac_rel    = offset_q - CntW'(MacFirst);

	// Pick the address byte that this offset is compared with.
	always_comb begin
		case (mac_rel[2:0])
			3'd0: mac_byte = own_mac[47:40];
			3'd1: mac_byte = own_mac[39:32];
			3'd2: mac_byte = own_mac[31:24];
			3'd3: mac_byte = own_mac[23:16];
			3'd4: mac_byte = own_mac[15:8];
			3'd5: mac_byte = own_mac[7:0];
			default: mac_byte = '0;
		endcase
	end

	// Classify the byte by its offset in the packet.
	always_comb begin
		push_item            = '0;
		push_item.data       = b;
		push_item.last       = pkt_in.last_byte;
		push_item.short_pkt  = count_next < CntW'(MinLen);
		if (take) begin
			push_item.op_bad = (offset_q == '0) && (b != ReplyOp);
			push_item.is_xid = (offset_q >= CntW'(XidFirst)) && (offset_q <= CntW'(XidLast));
			push_item.is_yi  = (offset_q >= CntW'(YiFirst)) && (offset_q <= CntW'(YiLast));
			push_item.mac_bad = (offset_q >= CntW'(MacFirst)) &&
				(offset_q <= CntW'(MacLast)) && (mac_byte != b);
			push_item.cookie_bad = (offset_q >= CntW'(CookFirst)) &&
				(offset_q <= CntW'(CookLast)) && (Cookie[offset_q[1:0]] != b);
			push_item.is_opt = offset_q >= CntW'(OptBase);
		end
	end

	// Offset counter restarts after the last byte of each packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (push) begin
			if (pkt_in.last_byte) begin
				offset_q <= '0;
			end else begin
				offset_q <= count_next;
			end
		end
	end

endmodule

### sv/dre_queue.sv
// Short register queue between the front end and the back end.
module dre_queue import dre_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head_item,
	output q_stat_t q_stat
);

	item_t            slot_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QPtrW:0]   count_q;

	assign head_item    = slot_q[rd_ptr_q];
	assign q_stat.full  = count_q == (QPtrW + 1)'(QDepth);
	assign q_stat.empty = count_q == '0;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPtrW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPtrW + 1)'(1);
			end
		end
	end

endmodule

### sv/dre_back.sv
// Back end: header checks, option walk and the summary output register.
module dre_back import dre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       head_item,
	input  q_stat_t     q_stat,
	input  logic [31:0] expected_xid,
	output logic        pop,
	output summary_t    res,
	output logic        res_valid,
	input  logic        res_ready
);

	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_VALUE,
		PH_DONE
	} phase_t;

	phase_t         phase_q, n_phase;
	logic [2:0]     fail_q, n_fail;
	logic [31:0]    xid_q, n_xid;
	logic [31:0]    yi_q, n_yi;
	byte_t          code_q, n_code;
	byte_t          rem_q, n_rem;
	byte_t          len_q, n_len;
	logic [31:0]    shift_q, n_shift;
	logic [NumWanted-1:0] seen_q, n_seen;
	logic [NumWanted-1:0] valid_q, n_valid;
	logic [NumWanted-1:0] cap_we;
	logic [31:0]    cap_q [NumWanted];
	logic [31:0]    cap_n [NumWanted];
	logic           finish;
	byte_t          fin_len;
	item_t          it;
	summary_t       sum;
	logic           res_valid_q;
	summary_t       res_q;

	assign it        = head_item;
	assign res       = res_q;
	assign res_valid = res_valid_q;

	// A last byte waits while an earlier summary has not been taken.
	assign pop = !q_stat.empty && (!it.last || !res_valid_q || res_ready);

	// Header fields and the option walk for the byte at the queue head.
	always_comb begin
		n_phase = phase_q;
		n_fail  = fail_q | {it.mac_bad, it.cookie_bad, it.op_bad};
		n_xid   = it.is_xid ? {xid_q[23:0], it.data} : xid_q;
		n_yi    = it.is_yi ? {yi_q[23:0], it.data} : yi_q;
		n_code  = code_q;
		n_rem   = rem_q;
		n_len   = len_q;
		n_shift = shift_q;
		finish  = 1'b0;
		fin_len = len_q;
		if (it.is_opt) begin
			case (phase_q)
				PH_CODE: begin
					if (it.data == OptEnd) begin
						n_phase = PH_DONE;
					end else if (it.data != OptPad) begin
						n_code  = it.data;
						n_phase = PH_LEN;
					end
				end
				PH_LEN: begin
					n_len   = it.data;
					n_rem   = it.data;
					n_shift = '0;
					fin_len = it.data;
					if (it.data == '0) begin
						finish  = 1'b1;
						n_phase = PH_CODE;
					end else begin
						n_phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					n_shift = {shift_q[23:0], it.data};
					n_rem   = rem_q - 8'd1;
					if (rem_q == 8'd1) begin
						finish  = 1'b1;
						n_phase = PH_CODE;
					end
				end
				default: begin
					n_phase = PH_DONE;
				end
			endcase
		end
	end

	// Only the first complete occurrence of each wanted option counts.
	always_comb begin
		n_seen  = seen_q;
		n_valid = valid_q;
		cap_we  = '0;
		for (int i = 0; i < NumWanted; i++) begin
			if (finish && (code_q == WantCode[i]) && !seen_q[i]) begin
				n_seen[i] = 1'b1;
				if (fin_len == WantLen[i]) begin
					n_valid[i] = 1'b1;
					cap_we[i]  = 1'b1;
				end
			end
			cap_n[i] = cap_we[i] ? n_shift : cap_q[i];
		end
	end

	// Summary of the packet as it stands after this byte.
	always_comb begin
		sum            = '0;
		sum.lease_secs = DefaultLease;
		if (it.short_pkt) begin
			sum.verdict = VERD_SHORT;
		end else if (n_fail[0]) begin
			sum.verdict = VERD_NOT_REPLY;
		end else if (n_fail[1]) begin
			sum.verdict = VERD_BAD_COOKIE;
		end else if (n_fail[2]) begin
			sum.verdict = VERD_OTHER_MAC;
		end else if (n_xid != expected_xid) begin
			sum.verdict = VERD_XID;
		end else begin
			sum.verdict = VERD_OK;
		end
		if (sum.verdict == VERD_OK) begin
			sum.message_kind   = n_valid[SlotMsg] ? cap_n[SlotMsg][7:0] : '0;
			sum.offered_ip     = n_yi;
			sum.server_id_ok   = n_valid[SlotSrv];
			sum.server_addr    = n_valid[SlotSrv] ? cap_n[SlotSrv] : '0;
			sum.lease_present  = n_valid[SlotLease];
			if (n_valid[SlotLease] && (cap_n[SlotLease] != '0)) begin
				sum.lease_secs = cap_n[SlotLease];
			end
			sum.netmask        = n_valid[SlotMask] ? cap_n[SlotMask] : '0;
			sum.gateway_ip     = n_valid[SlotGw] ? cap_n[SlotGw] : '0;
			sum.name_server_ip = n_valid[SlotDns] ? cap_n[SlotDns] : '0;
		end
	end

	// Walk state, captured values and the summary register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CODE;
			fail_q      <= '0;
			xid_q       <= '0;
			yi_q        <= '0;
			code_q      <= '0;
			rem_q       <= '0;
			len_q       <= '0;
			shift_q     <= '0;
			seen_q      <= '0;
			valid_q     <= '0;
			for (int i = 0; i < NumWanted; i++) begin
				cap_q[i] <= '0;
			end
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (pop) begin
				for (int i = 0; i < NumWanted; i++) begin
					cap_q[i] <= cap_n[i];
				end
				if (it.last) begin
					phase_q <= PH_CODE;
					fail_q  <= '0;
					xid_q   <= '0;
					yi_q    <= '0;
					code_q  <= '0;
					rem_q   <= '0;
					len_q   <= '0;
					shift_q <= '0;
					seen_q  <= '0;
					valid_q <= '0;
				end else begin
					phase_q <= n_phase;
					fail_q  <= n_fail;
					xid_q   <= n_xid;
					yi_q    <= n_yi;
					code_q  <= n_code;
					rem_q   <= n_rem;
					len_q   <= n_len;
					shift_q <= n_shift;
					seen_q  <= n_seen;
					valid_q <= n_valid;
				end
			end
			if (pop && it.last) begin
				res_valid_q <= 1'b1;
				res_q       <= sum;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/dhcp_reply_field_extractor.sv
// Top level of the DHCP reply field extractor.
//
//   Channel   Dir  Payload                               Transfer
//   pkt_in    in   data_byte, last_byte                  valid && ready
//   summary   out  verdict and nine extracted fields     valid && ready
//   cfg       in   cfg_index, cfg_data (own_mac, xid)    cfg_we
//
// One byte is taken per cycle unless the queue is full.
// Bytes pass through a four-entry queue; the front stalls only when it is full.
// The back end holds a last byte while the previous summary is not yet taken.
// Reset clears the offset counter, queue, walk state and both config registers.
`include "assert_macros.svh"

module dhcp_reply_field_extractor import dre_pkg::*; #(
	parameter int unsigned MAX_BYTES = 1500
) (
	input  logic        clk,
	input  logic        arst_n,
	dre_byte_if.sink    pkt_in,
	dre_sum_if.source   summary,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data
);

	logic [47:0] own_mac_q;
	logic [31:0] expected_xid_q;
	logic        push;
	item_t       push_item;
	logic        pop;
	item_t       head_item;
	q_stat_t     q_stat;
	summary_t    res;
	logic        res_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q      <= '0;
			expected_xid_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgOwnMac: own_mac_q      <= cfg_data;
				CfgXid:    expected_xid_q <= cfg_data[31:0];
				default:   own_mac_q      <= own_mac_q;
			endcase
		end
	end

	dre_front #(
		.MAX_BYTES (MAX_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_in    (pkt_in),
		.own_mac   (own_mac_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	dre_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	dre_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (head_item),
		.q_stat       (q_stat),
		.expected_xid (expected_xid_q),
		.pop          (pop),
		.res          (res),
		.res_valid    (res_valid),
		.res_ready    (summary.ready)
	);

	// Summary channel driven from the output register.
	assign summary.valid          = res_valid;
	assign summary.verdict        = res.verdict;
	assign summary.message_kind   = res.message_kind;
	assign summary.offered_ip     = res.offered_ip;
	assign summary.server_id_ok   = res.server_id_ok;
	assign summary.server_addr    = res.server_addr;
	assign summary.lease_present  = res.lease_present;
	assign summary.lease_secs     = res.lease_secs;
	assign summary.netmask        = res.netmask;
	assign summary.gateway_ip     = res.gateway_ip;
	assign summary.name_server_ip = res.name_server_ip;

	// The queue never overflows or underflows.
	`DRE_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !q_stat.full)
	`DRE_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !q_stat.empty)
	// A last byte leaving the queue is always followed by a summary.
	`DRE_ASSERT_NEXT(a_sum_from_last, clk, arst_n, pop && head_item.last, summary.valid)
	// A rejected packet reports no option content.
	`DRE_ASSERT_NOW(a_reject_clean, clk, arst_n,
		summary.valid && (summary.verdict != VERD_OK),
		(summary.message_kind == '0) && (summary.lease_secs == DefaultLease))

endmodule
